### rtl/core/mfp_pkg.sv
package mfp_pkg;

    // Default pool geometry
    localparam int SLOT_COUNT_DEF = 4;
    localparam int SLOT_BYTES_DEF = 8;

    // Command codes
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_LONG  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    // One result as it leaves the sequencer
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_byte;
        logic [3:0] msg_length;
        logic       last_of_run;
        logic [5:0] total_bytes;
    } t_result;

endpackage

### rtl/core/mfp_ctrl.sv
module mfp_ctrl #(
    parameter int SLOT_COUNT = mfp_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = mfp_pkg::SLOT_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic [1:0]       i_command,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    input  logic             i_out_free,
    output logic             o_ready,
    output logic             o_res_valid,
    output mfp_pkg::t_result o_res
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int PW = $clog2(SLOT_BYTES + 1);
    localparam int AW = (SLOT_COUNT * SLOT_BYTES > 1) ? $clog2(SLOT_COUNT * SLOT_BYTES) : 1;
    localparam int QW = $clog2(SLOT_COUNT * SLOT_BYTES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LEN  = 3'b010,
        S_POP  = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [SW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [QW-1:0]   r_qbytes, n_qbytes;
    logic [PW-1:0]   r_pos, n_pos;
    logic            r_ovf, n_ovf;
    logic            r_blk, n_blk;
    logic [SW-1:0]   r_pop_slot, n_pop_slot;
    logic [PW-1:0]   r_pop_len, n_pop_len;
    logic [PW-1:0]   r_pop_idx, n_pop_idx;

    // Message byte store and slot length store
    logic [7:0]      byte_mem [SLOT_COUNT * SLOT_BYTES];
    logic [PW-1:0]   len_mem  [SLOT_COUNT];
    logic [7:0]      r_byte_rd;
    logic [PW-1:0]   r_len_rd;

    logic            byte_we, byte_re, len_we, len_re;
    logic [AW-1:0]   byte_waddr, byte_raddr;
    logic [SW-1:0]   len_waddr;
    logic [PW-1:0]   len_wdata;

    logic            accept, full, blk_now, ovf_now;
    logic [SW-1:0]   tail;
    logic [PW-1:0]   pos_inc, len_fix, idx_next, rd_idx;
    int              tsum;

    assign o_ready = (r_state == S_IDLE) && i_out_free;
    assign accept  = i_req_valid && o_ready;

    // Locate the slot after the last queued message
    always_comb begin
        tsum = int'(r_head) + int'(r_count);
        if (tsum >= SLOT_COUNT) begin
            tsum = tsum - SLOT_COUNT;
        end
        tail = SW'(tsum);
    end

    assign full     = int'(r_count) >= SLOT_COUNT;
    assign blk_now  = r_blk || full;
    assign ovf_now  = r_ovf || (int'(r_pos) >= SLOT_BYTES);
    assign pos_inc  = (int'(r_pos) < SLOT_BYTES) ? r_pos + PW'(1) : r_pos;
    assign idx_next = r_pop_idx + PW'(1);
    assign rd_idx   = (r_state == S_LEN) ? '0 : idx_next;

    // Clamp the stored length into one to SLOT_BYTES
    always_comb begin
        len_fix = r_len_rd;
        if (int'(r_len_rd) > SLOT_BYTES) begin
            len_fix = PW'(SLOT_BYTES);
        end
        if (r_len_rd == '0) begin
            len_fix = PW'(1);
        end
    end

    assign byte_waddr = AW'(int'(tail) * SLOT_BYTES + int'(r_pos));
    assign byte_raddr = AW'(int'(r_pop_slot) * SLOT_BYTES + int'(rd_idx));
    assign len_waddr  = tail;
    assign len_wdata  = pos_inc;

    // Sequence appends, pops and flushes
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_qbytes    = r_qbytes;
        n_pos       = r_pos;
        n_ovf       = r_ovf;
        n_blk       = r_blk;
        n_pop_slot  = r_pop_slot;
        n_pop_len   = r_pop_len;
        n_pop_idx   = r_pop_idx;
        byte_we     = 1'b0;
        byte_re     = 1'b0;
        len_we      = 1'b0;
        len_re      = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{status: mfp_pkg::ST_OK, out_byte: 8'd0, msg_length: 4'd0,
                        last_of_run: 1'b1, total_bytes: 6'(r_qbytes)};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        mfp_pkg::CMD_APPEND: begin
                            // store the byte while the pool is not full and room remains in the slot
                            byte_we = !full && (int'(r_pos) < SLOT_BYTES);
                            if (i_last_byte) begin
                                o_res_valid = 1'b1;
                                n_pos = '0;
                                n_ovf = 1'b0;
                                n_blk = 1'b0;
                                if (blk_now) begin
                                    o_res.status = mfp_pkg::ST_FULL;
                                end else if (ovf_now) begin
                                    o_res.status = mfp_pkg::ST_LONG;
                                end else begin
                                    len_we   = 1'b1;
                                    n_count  = r_count + CW'(1);
                                    n_qbytes = r_qbytes + QW'(pos_inc);
                                    o_res.msg_length  = 4'(pos_inc);
                                    o_res.total_bytes = 6'(r_qbytes + QW'(pos_inc));
                                end
                            end else begin
                                n_pos = pos_inc;
                                n_ovf = ovf_now;
                                n_blk = blk_now;
                            end
                        end
                        mfp_pkg::CMD_POP: begin
                            if (r_count == '0) begin
                                o_res_valid  = 1'b1;
                                o_res.status = mfp_pkg::ST_EMPTY;
                            end else begin
                                len_re     = 1'b1;
                                n_pop_slot = r_head;
                                n_state    = S_LEN;
                            end
                        end
                        mfp_pkg::CMD_FLUSH: begin
                            n_count  = '0;
                            n_qbytes = '0;
                            n_pos    = '0;
                            n_ovf    = 1'b0;
                            n_blk    = 1'b0;
                            o_res_valid       = 1'b1;
                            o_res.status      = mfp_pkg::ST_FLUSH;
                            o_res.total_bytes = 6'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LEN: begin
                // retire the head slot and fetch its first byte
                n_pop_len = len_fix;
                n_pop_idx = '0;
                n_head    = (int'(r_head) + 1 >= SLOT_COUNT) ? '0 : r_head + SW'(1);
                n_count   = r_count - CW'(1);
                n_qbytes  = (r_qbytes >= QW'(len_fix)) ? r_qbytes - QW'(len_fix) : '0;
                byte_re   = 1'b1;
                n_state   = S_POP;
            end
            S_POP: begin
                if (i_out_free) begin
                    o_res_valid       = 1'b1;
                    o_res.out_byte    = r_byte_rd;
                    o_res.msg_length  = 4'(r_pop_len);
                    o_res.last_of_run = (idx_next == r_pop_len);
                    if (idx_next == r_pop_len) begin
                        n_state = S_IDLE;
                    end else begin
                        byte_re   = 1'b1;
                        n_pop_idx = idx_next;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Write and read the stores
    always_ff @(posedge i_clk) begin
        if (byte_we) begin
            byte_mem[byte_waddr] <= i_data_byte;
        end
        if (byte_re) begin
            r_byte_rd <= byte_mem[byte_raddr];
        end
        if (len_we) begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (len_re) begin
            r_len_rd <= len_mem[r_head];
        end
    end

    // Hold queue and build state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_qbytes <= '0;
            r_pos    <= '0;
            r_ovf    <= 1'b0;
            r_blk    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_qbytes <= n_qbytes;
            r_pos    <= n_pos;
            r_ovf    <= n_ovf;
            r_blk    <= n_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_slot <= n_pop_slot;
        r_pop_len  <= n_pop_len;
        r_pop_idx  <= n_pop_idx;
    end

endmodule

### rtl/core/message_fifo_pool.sv
// Message queue over a pool of SLOT_COUNT slots of SLOT_BYTES bytes each.
// Input channel: i_valid / o_stall with i_command, i_data_byte, i_last_byte.
// An append request carries one byte; the request with i_last_byte set closes
// the message and yields one result (ok with length, full, or too long).
// A pop request yields one result per byte of the oldest message, or a single
// empty result; a flush request yields one flushed result.
// Output channel: o_valid / i_stall; each result passes through an output register.
// o_last_of_run marks the final result of a request; o_total_bytes carries
// the queued byte total after that request.
// Append, flush and empty pop yield their result in the cycle after
// acceptance. A pop reads the slot length store, then the first byte, then
// one byte per cycle while the receiver does not stall, out of the byte
// store's registered read port.
// One request is in work at a time; o_stall stays high until it has issued
// its last result into the output register.
// While the receiver stalls, the output register holds its result and the
// sequencer waits.
// Reset empties the queue and drops any partial message; the stores keep
// their contents and are only read where written.
module message_fifo_pool #(
    parameter int SLOT_COUNT = mfp_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = mfp_pkg::SLOT_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [7:0] o_out_byte,
    output logic [3:0] o_msg_length,
    output logic       o_last_of_run,
    output logic [5:0] o_total_bytes
);

    logic             out_free, ready, res_valid;
    mfp_pkg::t_result res;
    mfp_pkg::t_result r_out;
    logic             r_valid;

    assign out_free = !r_valid || !i_stall;
    assign o_stall  = !ready;

    mfp_ctrl #(
        .SLOT_COUNT(SLOT_COUNT),
        .SLOT_BYTES(SLOT_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_valid),
        .i_command  (i_command),
        .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte),
        .i_out_free (out_free),
        .o_ready    (ready),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    // Load the output register when it is empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_out.status;
    assign o_out_byte    = r_out.out_byte;
    assign o_msg_length  = r_out.msg_length;
    assign o_last_of_run = r_out.last_of_run;
    assign o_total_bytes = r_out.total_bytes;

endmodule
